// ===== rtl/spq_pkg.sv =====
// spq_pkg: shared types and constants for the stable priority queue
// operation codes, status codes and the cell command struct
// no dependencies
package spq_pkg;

  localparam int DefDepth     = 16;
  localparam int DefDataWidth = 32;
  localparam int DefPrioWidth = 16;

  localparam int FuncWidth   = 2;
  localparam int StatusWidth = 2;

  localparam logic [FuncWidth-1:0] FuncPush  = 2'd0;
  localparam logic [FuncWidth-1:0] FuncPop   = 2'd1;
  localparam logic [FuncWidth-1:0] FuncClear = 2'd2;

  localparam logic [StatusWidth-1:0] StatusOk    = 2'd0;
  localparam logic [StatusWidth-1:0] StatusEmpty = 2'd1;
  localparam logic [StatusWidth-1:0] StatusFull  = 2'd2;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic push;
    logic pop;
  } spq_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted row, holds data and priority
// shifts right on push behind the insert point, left on pop
// depends on spq_pkg
module spq_cell import spq_pkg::*; #(
  parameter int DataWidth = DefDataWidth,
  parameter int PrioWidth = DefPrioWidth
) (
  input  logic                        clk_i,
  input  spq_cmd_t                    cmd_i,
  input  logic                        occ_i,       // slot holds a live entry
  input  logic        [DataWidth-1:0] new_data_i,
  input  logic signed [PrioWidth-1:0] new_prio_i,
  input  logic                        left_ge_i,   // left neighbor stays put
  input  logic        [DataWidth-1:0] left_data_i,
  input  logic signed [PrioWidth-1:0] left_prio_i,
  input  logic        [DataWidth-1:0] right_data_i,
  input  logic signed [PrioWidth-1:0] right_prio_i,
  output logic                        ge_o,
  output logic        [DataWidth-1:0] data_o,
  output logic signed [PrioWidth-1:0] prio_o
);

  logic        [DataWidth-1:0] data_q, data_d;
  logic signed [PrioWidth-1:0] prio_q, prio_d;

  // live entry that ranks at or above the new one keeps its place
  assign ge_o = occ_i && (prio_q >= new_prio_i);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (cmd_i.push && !ge_o) begin
      if (left_ge_i) begin
        data_d = new_data_i;
        prio_d = new_prio_i;
      end else begin
        data_d = left_data_i;
        prio_d = left_prio_i;
      end
    end else if (cmd_i.pop) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule

// ===== rtl/stable_priority_queue_top.sv =====
// stable_priority_queue_top: bounded sorted priority queue on stream ports
// row of spq_cell slots plus the entry counter and the response register
// depends on spq_pkg and spq_cell
//
// Each request (push, pop or clear, chosen by s_axis_tuser_i) is taken at a
// clock edge and its response is registered, valid in the cycle that follows.
// The queue is a row of Depth cells sorted by priority, head in cell 0. A push
// is resolved in parallel: every cell compares its own priority with the
// new one, the cells at or above it stay, the first cell below takes the new
// item and the rest shift one place toward the tail, so equal priorities leave
// first in first out. A pop shifts the whole row one place toward the head and
// returns the old head. A clear only zeroes the entry counter. A push to a full
// queue is dropped with status full, a pop of an empty queue answers status
// empty. Throughput is one request per cycle while the response side keeps up;
// the single response register holds a result until it is taken, and
// s_axis_tready_o is low for as long as a result waits, so the rate is set by
// that register. Every response carries the fill count after the request.
module stable_priority_queue_top import spq_pkg::*; #(
  parameter int Depth     = DefDepth,
  parameter int DataWidth = DefDataWidth,
  parameter int PrioWidth = DefPrioWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  // request side
  input  logic                                            s_axis_tvalid_i,
  output logic                                            s_axis_tready_o,
  // item_data, item_prio, zero padding
  input  logic [((DataWidth+PrioWidth+7)/8)*8-1:0]        s_axis_tdata_i,
  // func
  input  logic [FuncWidth-1:0]                            s_axis_tuser_i,
  // response side
  output logic                                            m_axis_tvalid_o,
  input  logic                                            m_axis_tready_i,
  // out_data, out_prio, fill_count, zero padding
  output logic [((DataWidth+PrioWidth+$clog2(Depth+1)+7)/8)*8-1:0] m_axis_tdata_o,
  // out_valid, status
  output logic [StatusWidth:0]                            m_axis_tuser_o
);

  localparam int CntWidth  = $clog2(Depth + 1);
  localparam int InDataW   = ((DataWidth + PrioWidth + 7) / 8) * 8;
  localparam int OutFieldW = DataWidth + PrioWidth + CntWidth;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // request fields
  logic                        accept;
  logic [FuncWidth-1:0]        func;
  logic        [DataWidth-1:0] item_data;
  logic signed [PrioWidth-1:0] item_prio;

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign func      = s_axis_tuser_i;
  assign item_data = s_axis_tdata_i[DataWidth-1:0];
  assign item_prio = $signed(s_axis_tdata_i[DataWidth+PrioWidth-1:DataWidth]);

  // entry counter
  logic [CntWidth-1:0] count_q, count_d;
  logic                full, empty;
  spq_cmd_t            cmd;
  logic                clear;

  assign full  = (count_q == CntWidth'(Depth));
  assign empty = (count_q == '0);

  always_comb begin
    cmd.push = accept && (func == FuncPush) && !full;
    cmd.pop  = accept && (func == FuncPop) && !empty;
    clear    = accept && (func == FuncClear);
  end

  always_comb begin
    count_d = count_q;
    if (cmd.push) begin
      count_d = count_q + CntWidth'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CntWidth'(1);
    end else if (clear) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // the cell row, head at index 0
  logic        [DataWidth-1:0] cell_data [Depth];
  logic signed [PrioWidth-1:0] cell_prio [Depth];
  logic                        cell_ge   [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                        occ;
    logic                        left_ge;
    logic        [DataWidth-1:0] left_data;
    logic signed [PrioWidth-1:0] left_prio;
    logic        [DataWidth-1:0] right_data;
    logic signed [PrioWidth-1:0] right_prio;

    // slots at or past the count hold stale words and never rank
    assign occ = (CntWidth'(i) < count_q);

    if (i == 0) begin : g_head
      // head has no left neighbor: a non-ranking head always takes the new item
      assign left_ge   = 1'b1;
      assign left_data = '0;
      assign left_prio = '0;
    end else begin : g_body
      assign left_ge   = cell_ge[i-1];
      assign left_data = cell_data[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_data = '0;
      assign right_prio = '0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell #(
      .DataWidth(DataWidth),
      .PrioWidth(PrioWidth)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ),
      .new_data_i   (item_data),
      .new_prio_i   (item_prio),
      .left_ge_i    (left_ge),
      .left_data_i  (left_data),
      .left_prio_i  (left_prio),
      .right_data_i (right_data),
      .right_prio_i (right_prio),
      .ge_o         (cell_ge[i]),
      .data_o       (cell_data[i]),
      .prio_o       (cell_prio[i])
    );
  end

  // response register
  logic                        rsp_valid_q;
  logic                        out_valid_q, out_valid_d;
  logic [DataWidth-1:0]        out_data_q, out_data_d;
  logic [PrioWidth-1:0]        out_prio_q, out_prio_d;
  logic [StatusWidth-1:0]      status_q, status_d;
  logic [CntWidth-1:0]         fill_q;

  always_comb begin
    out_valid_d = cmd.pop;
    out_data_d  = '0;
    out_prio_d  = '0;
    status_d    = StatusOk;
    if (cmd.pop) begin
      out_data_d = cell_data[0];
      out_prio_d = cell_prio[0];
    end
    if (accept && (func == FuncPop) && empty) begin
      status_d = StatusEmpty;
    end else if (accept && (func == FuncPush) && full) begin
      status_d = StatusFull;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_prio_q  <= out_prio_d;
      status_q    <= status_d;
      fill_q      <= count_d;
    end
  end

  // take a new request only when the response slot is free or draining
  assign s_axis_tready_o = !rsp_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = rsp_valid_q;
  assign m_axis_tdata_o  = OutDataW'({fill_q, out_prio_q, out_data_q});
  assign m_axis_tuser_o  = {status_q, out_valid_q};

  // upper request bits are padding
  if (InDataW > DataWidth + PrioWidth) begin : g_pad
    logic unused_pad;
    assign unused_pad = ^s_axis_tdata_i[InDataW-1:DataWidth+PrioWidth];
  end

endmodule

// ===== rtl/spq_checker.sv =====
// spq_checker: port level checks for stable_priority_queue_top
// bound to the top level below
// depends on spq_pkg
module spq_checker import spq_pkg::*; #(
  parameter int Depth     = DefDepth,
  parameter int DataWidth = DefDataWidth,
  parameter int PrioWidth = DefPrioWidth
) (
  input logic                                                  clk_i,
  input logic                                                  rst_ni,
  input logic                                                  s_axis_tvalid_i,
  input logic                                                  s_axis_tready_o,
  input logic                                                  m_axis_tvalid_o,
  input logic                                                  m_axis_tready_i,
  input logic [((DataWidth+PrioWidth+$clog2(Depth+1)+7)/8)*8-1:0] m_axis_tdata_o,
  input logic [StatusWidth:0]                                  m_axis_tuser_o
);

  localparam int CntWidth = $clog2(Depth + 1);

  logic [CntWidth-1:0]    fill;
  logic [StatusWidth-1:0] status;
  logic                   out_valid;

  assign fill      = m_axis_tdata_o[DataWidth+PrioWidth+CntWidth-1:DataWidth+PrioWidth];
  assign status    = m_axis_tuser_o[StatusWidth:1];
  assign out_valid = m_axis_tuser_o[0];

  // a stalled response blocks new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("request taken while response stalled");

  // every accepted request yields a response next cycle
  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> m_axis_tvalid_o)
    else $error("response missing after request");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (fill <= CntWidth'(Depth)))
    else $error("fill count beyond depth");

  // empty answer leaves the queue empty, full answer leaves it full
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (status == StatusEmpty)) |-> (fill == '0) && !out_valid)
    else $error("empty status with entries stored");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (status == StatusFull)) |-> (fill == CntWidth'(Depth)) && !out_valid)
    else $error("full status with free slots");

endmodule

bind stable_priority_queue_top spq_checker #(
  .Depth     (Depth),
  .DataWidth (DataWidth),
  .PrioWidth (PrioWidth)
) u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== sim/testbench.sv =====
// testbench: self-checking bench for stable_priority_queue_top
// shadow sorted queue predicts each response, directed table then random requests
// depends on spq_pkg and the rtl of stable_priority_queue_top
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int Depth      = DefDepth;
  localparam int DataWidth  = DefDataWidth;
  localparam int PrioWidth  = DefPrioWidth;
  localparam int CountWidth = $clog2(Depth + 1);
  localparam int ReqWidth   = ((DataWidth + PrioWidth + 7) / 8) * 8;
  localparam int RspWidth   = ((DataWidth + PrioWidth + CountWidth + 7) / 8) * 8;

  // func code the block treats as a no-op
  localparam logic [FuncWidth-1:0] FuncUnused = 2'd3;

  localparam int RandomRequests = 1300;
  localparam int IdleLimit      = 2000;
  localparam int DrainCycles    = 8;
  localparam int NumRows        = 25;

  typedef struct packed {
    logic                        out_valid;
    logic [DataWidth-1:0]        out_data;
    logic [PrioWidth-1:0]        out_prio;
    logic [StatusWidth-1:0]      status;
    logic [CountWidth-1:0]       fill_count;
  } response_t;

  // one directed request; count repeats it with the data word stepping by one
  typedef struct packed {
    logic [FuncWidth-1:0]        func;
    logic [DataWidth-1:0]        data;
    logic [PrioWidth-1:0]        prio;
    logic [7:0]                  count;
    logic                        typed;
    response_t                   want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [ReqWidth-1:0]   s_axis_tdata_i  = '0;   // item_data, item_prio
  logic [FuncWidth-1:0]  s_axis_tuser_i  = FuncPush; // func
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [RspWidth-1:0]   m_axis_tdata_o;         // out_data, out_prio, fill_count
  logic [StatusWidth:0]  m_axis_tuser_o;         // out_valid, status

  stable_priority_queue_top #(
    .Depth    (Depth),
    .DataWidth(DataWidth),
    .PrioWidth(PrioWidth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the sorted queue, head at index 0
  logic [DataWidth-1:0]        shadow_data [Depth];
  logic signed [PrioWidth-1:0] shadow_prio [Depth];
  int                          shadow_fill = 0;

  response_t pending_responses [$];
  int        mismatch_count = 0;
  int        burst_left = 0;

  // directed table: typed expectations only where they are obvious
  stim_row_t directed_rows [NumRows] = '{
    // pop and clear on an empty queue, then the unused code
    '{FuncPop,    32'h0,        16'h0,    8'd1,  1'b1, '{1'b0, 32'h0, 16'h0, StatusEmpty, 5'd0}},
    '{FuncClear,  32'h0,        16'h0,    8'd1,  1'b1, '{1'b0, 32'h0, 16'h0, StatusOk, 5'd0}},
    '{FuncUnused, 32'hffffffff, 16'hffff, 8'd1,  1'b1, '{1'b0, 32'h0, 16'h0, StatusOk, 5'd0}},
    // extreme priorities and data words
    '{FuncPush,   32'hffffffff, 16'h7fff, 8'd1,  1'b1, '{1'b0, 32'h0, 16'h0, StatusOk, 5'd1}},
    '{FuncPush,   32'h00000000, 16'h8000, 8'd1,  1'b1, '{1'b0, 32'h0, 16'h0, StatusOk, 5'd2}},
    // equal priorities must leave in arrival order
    '{FuncPush,   32'h11111111, 16'h0000, 8'd1,  1'b0, '0},
    '{FuncPush,   32'h22222222, 16'h0000, 8'd1,  1'b0, '0},
    '{FuncPush,   32'h33333333, 16'h0000, 8'd1,  1'b0, '0},
    '{FuncPush,   32'haaaaaaaa, 16'hffff, 8'd1,  1'b0, '0},
    '{FuncPop,    32'h0,        16'h0,    8'd1,  1'b1,
      '{1'b1, 32'hffffffff, 16'h7fff, StatusOk, 5'd5}},
    '{FuncPop,    32'h0,        16'h0,    8'd4,  1'b0, '0},
    '{FuncPop,    32'h0,        16'h0,    8'd1,  1'b1,
      '{1'b1, 32'h00000000, 16'h8000, StatusOk, 5'd0}},
    '{FuncPop,    32'h0,        16'h0,    8'd1,  1'b1, '{1'b0, 32'h0, 16'h0, StatusEmpty, 5'd0}},
    // fill to the top, then push into a full queue
    '{FuncPush,   32'h5a5a0000, 16'h0005, 8'd16, 1'b0, '0},
    '{FuncPush,   32'hdeadbeef, 16'h7fff, 8'd1,  1'b1, '{1'b0, 32'h0, 16'h0, StatusFull, 5'd16}},
    '{FuncUnused, 32'h0,        16'h0,    8'd1,  1'b1, '{1'b0, 32'h0, 16'h0, StatusOk, 5'd16}},
    '{FuncPop,    32'h0,        16'h0,    8'd3,  1'b0, '0},
    '{FuncPush,   32'h00000100, 16'h0064, 8'd1,  1'b0, '0},
    '{FuncPush,   32'hc0000000, 16'hff9c, 8'd1,  1'b0, '0},
    '{FuncPop,    32'h0,        16'h0,    8'd2,  1'b0, '0},
    // clear a loaded queue
    '{FuncClear,  32'h0,        16'h0,    8'd1,  1'b1, '{1'b0, 32'h0, 16'h0, StatusOk, 5'd0}},
    '{FuncPop,    32'h0,        16'h0,    8'd1,  1'b1, '{1'b0, 32'h0, 16'h0, StatusEmpty, 5'd0}},
    '{FuncPush,   32'h00000001, 16'h0001, 8'd3,  1'b0, '0},
    '{FuncPush,   32'h80000000, 16'h0002, 8'd1,  1'b0, '0},
    '{FuncPop,    32'h0,        16'h0,    8'd4,  1'b0, '0}
  };

  // response of the queue to one request, updating the shadow copy
  function automatic response_t queue_response(input logic [FuncWidth-1:0] func,
                                               input logic [DataWidth-1:0] data,
                                               input logic signed [PrioWidth-1:0] prio);
    response_t rsp;
    int pos;
    int i;
    rsp = '0;
    rsp.status = StatusOk;
    case (func)
      FuncPush: begin
        if (shadow_fill >= Depth) begin
          rsp.status = StatusFull;
        end else begin
          // new entry goes behind every entry of greater or equal priority
          pos = 0;
          while (pos < shadow_fill && shadow_prio[pos] >= prio) pos++;
          for (i = shadow_fill; i > pos; i--) begin
            shadow_data[i] = shadow_data[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_data[pos] = data;
          shadow_prio[pos] = prio;
          shadow_fill++;
        end
      end
      FuncPop: begin
        if (shadow_fill == 0) begin
          rsp.status = StatusEmpty;
        end else begin
          rsp.out_valid = 1'b1;
          rsp.out_data  = shadow_data[0];
          rsp.out_prio  = shadow_prio[0];
          for (i = 1; i < shadow_fill; i++) begin
            shadow_data[i-1] = shadow_data[i];
            shadow_prio[i-1] = shadow_prio[i];
          end
          shadow_fill--;
        end
      end
      FuncClear: shadow_fill = 0;
      default: ;
    endcase
    rsp.fill_count = shadow_fill[CountWidth-1:0];
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("%0t ns mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // drive one request, honoring the burst and gap pattern of the sender;
  // called and left at a rising edge
  task automatic send_request(input logic [FuncWidth-1:0] func,
                              input logic [DataWidth-1:0] data,
                              input logic [PrioWidth-1:0] prio,
                              input logic typed, input response_t want);
    response_t predicted;
    logic accepted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {prio, data};
    s_axis_tuser_i  <= func;
    accepted = 1'b0;
    while (!accepted) begin
      // inputs are settled at the falling edge; the transfer happens at the next rise
      @(negedge clk_i);
      accepted = s_axis_tready_o;
      if (accepted) begin
        predicted = queue_response(func, data, prio);
        pending_responses.push_back(typed ? want : predicted);
      end
      @(posedge clk_i);
    end
  endtask

  // receiver: stretches of always ready, light, heavy and very heavy stalls
  int ready_mode = 0;
  int ready_left = 0;
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(8, 64);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: m_axis_tready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // response check, sampled at the falling edge before the transfer edge
  always @(negedge clk_i) begin : check_response
    response_t got;
    response_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.out_data   = m_axis_tdata_o[DataWidth-1:0];
      got.out_prio   = m_axis_tdata_o[DataWidth+PrioWidth-1:DataWidth];
      got.fill_count = m_axis_tdata_o[DataWidth+PrioWidth+CountWidth-1:DataWidth+PrioWidth];
      got.out_valid  = m_axis_tuser_o[0];
      got.status     = m_axis_tuser_o[StatusWidth:1];
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected response", 64'(m_axis_tdata_o), 64'h0);
      end else begin
        want = pending_responses.pop_front();
        if (got.out_valid !== want.out_valid)
          report_mismatch("out_valid", 64'(got.out_valid), 64'(want.out_valid));
        if (got.out_data !== want.out_data)
          report_mismatch("out_data", 64'(got.out_data), 64'(want.out_data));
        if (got.out_prio !== want.out_prio)
          report_mismatch("out_prio", 64'(got.out_prio), 64'(want.out_prio));
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.fill_count !== want.fill_count)
          report_mismatch("fill_count", 64'(got.fill_count), 64'(want.fill_count));
      end
    end
  end

  // watchdog: ends the run after a long stretch with no transfer on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(negedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int row;
    int k;
    int n;
    int phase_left;
    int push_weight;
    int roll;
    logic [FuncWidth-1:0] func;
    logic [DataWidth-1:0] data;
    logic [PrioWidth-1:0] prio;
    phase_left  = 0;
    push_weight = 50;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (row = 0; row < NumRows; row++) begin
      for (k = 0; k < directed_rows[row].count; k++) begin
        send_request(directed_rows[row].func, directed_rows[row].data + DataWidth'(k),
                     directed_rows[row].prio, directed_rows[row].typed,
                     directed_rows[row].want);
      end
    end

    // random requests in phases that lean toward filling, draining or neither,
    // so the queue keeps running into full and empty
    for (n = 0; n < RandomRequests; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(16, 80);
        case ($urandom_range(0, 2))
          0:       push_weight = 80;
          1:       push_weight = 20;
          default: push_weight = 50;
        endcase
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2)
        func = FuncClear;
      else if (roll < 4)
        func = FuncUnused;
      else if ($urandom_range(0, 99) < push_weight)
        func = FuncPush;
      else
        func = FuncPop;
      data = $urandom;
      // mostly a narrow set of priorities so ties are common
      roll = $urandom_range(0, 99);
      if (roll < 50)
        prio = PrioWidth'($urandom_range(0, 3)) - PrioWidth'(1);
      else if (roll < 60)
        prio = PrioWidth'($urandom_range(0, 16)) - PrioWidth'(8);
      else if (roll < 70)
        prio = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      else
        prio = PrioWidth'($urandom);
      send_request(func, data, prio, 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    // drain, then give a late or extra response time to show up
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
